[hdl/lru_atlas_slot_allocator_unit_macros.svh]
// Assertion helpers for the allocator top-level file.
`ifndef LRU_ATLAS_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define LRU_ATLAS_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LASA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lasa: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LASA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lasa: next-cycle check failed");

`endif

[hdl/lasa_pkg.sv]
package lasa_pkg;

  localparam int HELD_W = 11;
  localparam int ID_W   = 32;
  localparam int SLOT_W = 11;

  typedef struct packed {
    logic [HELD_W-1:0] held_slot;
    logic [ID_W-1:0]   item_id;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              evicted;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UNLINK,
    ST_LINK,
    ST_TERM,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch item, launch memory reads
    logic decide;    // capture hit / grant / evict decision
    logic unlink;    // splice chosen slot out of the order list
    logic link;      // append chosen slot at the most-recent end
    logic term;      // clear forward link of the appended slot
    logic load_out;  // load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_unlink;
    logic need_link;
    logic full;
  } status_t;

endpackage

[hdl/lasa_ctrl.sv]
module lasa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lasa_pkg::status_t sts_i,
  output lasa_pkg::cmd_t    cmd_o
);
  import lasa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.decide = 1'b1;
        if (sts_i.need_unlink) begin
          state_d = ST_UNLINK;
        end else if (sts_i.need_link) begin
          state_d = ST_LINK;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = ST_LINK;
      end
      ST_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = ST_TERM;
      end
      ST_TERM: begin
        cmd_o.term = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        // hold while the previous result is still stalled
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/lasa_dpath.sv]
module lasa_dpath #(
  parameter int NUM_SLOTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lasa_pkg::in_item_t  in_data_i,
  output lasa_pkg::out_item_t out_data_o,
  input  lasa_pkg::cmd_t      cmd_i,
  output lasa_pkg::status_t   sts_o
);
  import lasa_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS + 1);
  localparam int CW = (SW > HELD_W) ? SW : HELD_W;

  // Link and tag stores; entry 0 is unused, the list anchor lives in head_q / tail_q
  logic [SW-1:0]   nxt_mem [NUM_SLOTS+1];
  logic [SW-1:0]   prv_mem [NUM_SLOTS+1];
  logic [ID_W-1:0] tag_mem [NUM_SLOTS+1];

  logic [SW-1:0]   head_q, head_d, tail_q, tail_d, granted_q;
  logic            full_c;

  logic            held_ok_c;
  logic [SW-1:0]   held_idx_c;
  logic            held_ok_q;
  logic [SW-1:0]   held_idx_q;
  logic [ID_W-1:0] id_q;

  logic [SW-1:0]   nxt_rd_a_q, nxt_rd_b_q, prv_rd_q;
  logic [ID_W-1:0] tag_rd_q;

  logic            hit_c, grant_c, evict_c, unlink_c;
  logic [SW-1:0]   s_c, p_c, n_c;
  logic            hit_q, evict_q;
  logic [SW-1:0]   s_q, p_q, n_q;

  logic            nxt_we, prv_we, tag_we;
  logic [SW-1:0]   nxt_wa, nxt_wd, prv_wa, prv_wd;

  out_item_t       out_q;

  assign full_c     = (granted_q == SW'(NUM_SLOTS));
  assign held_ok_c  = (in_data_i.held_slot != '0) &&
                      (CW'(in_data_i.held_slot) <= CW'(granted_q));
  assign held_idx_c = held_ok_c ? SW'(in_data_i.held_slot) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      held_ok_q  <= held_ok_c;
      held_idx_q <= held_idx_c;
      id_q       <= in_data_i.item_id;
      nxt_rd_a_q <= nxt_mem[held_idx_c];
      nxt_rd_b_q <= nxt_mem[head_q];
      prv_rd_q   <= prv_mem[held_idx_c];
      tag_rd_q   <= tag_mem[held_idx_c];
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (tag_we) begin
      tag_mem[s_q] <= id_q;
    end
    if (cmd_i.decide) begin
      s_q     <= s_c;
      p_q     <= p_c;
      n_q     <= n_c;
      hit_q   <= hit_c;
      evict_q <= evict_c;
    end
    if (cmd_i.load_out) begin
      out_q.slot    <= SLOT_W'(s_q);
      out_q.hit     <= hit_q;
      out_q.evicted <= evict_q;
    end
  end

  // Hit test, then fresh grant while the pool lasts, else take the oldest slot
  always_comb begin
    hit_c    = held_ok_q && (tag_rd_q == id_q);
    grant_c  = 1'b0;
    evict_c  = 1'b0;
    unlink_c = 1'b0;
    s_c      = '0;
    p_c      = '0;
    n_c      = '0;
    if (hit_c) begin
      s_c      = held_idx_q;
      p_c      = prv_rd_q;
      n_c      = nxt_rd_a_q;
      unlink_c = (nxt_rd_a_q != '0);
    end else if (!full_c) begin
      s_c     = granted_q + SW'(1);
      grant_c = 1'b1;
    end else begin
      s_c      = head_q;
      n_c      = nxt_rd_b_q;
      unlink_c = (nxt_rd_b_q != '0);
      evict_c  = 1'b1;
    end
  end

  assign sts_o.need_unlink = unlink_c;
  assign sts_o.need_link   = !hit_c || unlink_c;
  assign sts_o.full        = full_c;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    nxt_we = 1'b0;
    nxt_wa = s_q;
    nxt_wd = '0;
    prv_we = 1'b0;
    prv_wa = s_q;
    prv_wd = '0;
    tag_we = 1'b0;
    if (cmd_i.unlink) begin
      if (p_q == '0) begin
        head_d = n_q;
      end else begin
        nxt_we = 1'b1;
        nxt_wa = p_q;
        nxt_wd = n_q;
      end
      prv_we = 1'b1;
      prv_wa = n_q;
      prv_wd = p_q;
    end
    if (cmd_i.link) begin
      if (tail_q == '0) begin
        head_d = s_q;
      end else begin
        nxt_we = 1'b1;
        nxt_wa = tail_q;
        nxt_wd = s_q;
      end
      prv_we = 1'b1;
      prv_wa = s_q;
      prv_wd = tail_q;
      tail_d = s_q;
      tag_we = !hit_q;
    end
    if (cmd_i.term) begin
      nxt_we = 1'b1;
      nxt_wa = s_q;
      nxt_wd = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      granted_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      if (cmd_i.decide && grant_c) begin
        granted_q <= granted_q + SW'(1);
      end
    end
  end

  assign out_data_o = out_q;

endmodule

[hdl/lru_atlas_slot_allocator_unit.sv]
// LRU slot allocator for a pool of NUM_SLOTS atlas cells.
// Input channel (in_valid_i / in_stall_o / in_data_i): one request item carries
// the slot the requester held before (0 for none) and its identifier.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one result
// item per request: the slot now owned, a hit flag and an evicted flag.
// Items are handled one at a time by a small controller stepping a datapath
// that keeps the recency order as a doubly linked list in link memories.
// From acceptance, a hit on the most-recent slot goes from lookup straight to
// the result; a fresh grant steps through link and termination; a hit that
// moves or an eviction steps through unlink, link and termination. The next
// item is taken after the result is loaded. The forward-link memory has a
// single write port, which takes up to three writes per item.
// Reset empties the list (anchor registers and grant count to zero); no
// clearing pass runs, entries are written before they are first read.
// A stalled result holds in the output register; the block still accepts and
// works on one further item, and holds before loading that item's result.
module lru_atlas_slot_allocator_unit #(
  parameter int NUM_SLOTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lasa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lasa_pkg::out_item_t out_data_o
);
  import lasa_pkg::*;
  `include "lru_atlas_slot_allocator_unit_macros.svh"

  cmd_t    cmd;
  status_t sts;

  // Sequence the lookup, unlink, link and termination steps
  lasa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the link and tag stores, the list anchor and the result register
  lasa_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  // An accepted item keeps the block busy for at least the next cycle
  `LASA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // A hit never reports an eviction
  `LASA_ASSERT_NOW(a_hit_not_evicted, out_valid_o && out_data_o.hit, !out_data_o.evicted)
  // Eviction only happens once every slot has been granted
  `LASA_ASSERT_NOW(a_evict_when_full, out_valid_o && out_data_o.evicted, sts.full)

endmodule
